// File: rtl/ggc_pkg.sv
// Shared types and constants for the greedy graph colouring block.
package ggc_pkg;

    // Fixed storage and field widths
    localparam int ROW_SLOTS        = 32;
    localparam int IDX_W            = 5;
    localparam int CNT_W            = 6;
    localparam int ROW_W            = 32;
    localparam int DEG_W            = 7;
    localparam int COLOR_W          = 6;
    localparam int IN_TDATA_W       = 40;
    localparam int OUT_TDATA_W      = 24;
    localparam int DEF_MAX_VERTICES = 32;

    localparam logic [CNT_W-1:0]        VCOUNT_RESET = 6'd32;
    localparam logic signed [DEG_W-1:0] DEGREE_DONE  = -7'sd1;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_SCAN_START,
        ST_SCAN,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_COLOR,
        ST_UPDATE,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic in_ready;
        logic start;
        logic init_wr;
        logic scan_start;
        logic scan_step;
        logic rd_best;
        logic row_latch;
        logic color_step;
        logic deg_update;
        logic out_load;
        logic out_next;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic in_accept;
        logic in_last;
        logic init_last;
        logic scan_done;
        logic color_found;
        logic last_round;
        logic out_taken;
        logic out_last;
    } t_status;

endpackage

// File: rtl/ggc_ctrl.sv
// Controller state machine for the greedy graph colouring block.
module ggc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ggc_pkg::t_status i_status,
    output ggc_pkg::t_cmd    o_cmd
);
    import ggc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_status.in_accept && i_status.in_last) n_state = ST_INIT_RD;
            end
            ST_INIT_RD:    n_state = ST_INIT_WR;
            ST_INIT_WR: begin
                n_state = i_status.init_last ? ST_SCAN_START : ST_INIT_RD;
            end
            ST_SCAN_START: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_ROW_RD;
            end
            ST_ROW_RD:     n_state = ST_ROW_WAIT;
            ST_ROW_WAIT:   n_state = ST_COLOR;
            ST_COLOR: begin
                if (i_status.color_found) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = i_status.last_round ? ST_OUT_LOAD : ST_SCAN_START;
            end
            ST_OUT_LOAD:   n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (i_status.out_taken) begin
                    n_state = i_status.out_last ? ST_IDLE : ST_OUT_LOAD;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.start    = i_status.in_accept && i_status.in_last;
            end
            ST_INIT_RD:    ;
            ST_INIT_WR:    o_cmd.init_wr    = 1'b1;
            ST_SCAN_START: o_cmd.scan_start = 1'b1;
            ST_SCAN:       o_cmd.scan_step  = !i_status.scan_done;
            ST_ROW_RD:     o_cmd.rd_best    = 1'b1;
            ST_ROW_WAIT:   o_cmd.row_latch  = 1'b1;
            ST_COLOR:      o_cmd.color_step = 1'b1;
            ST_UPDATE:     o_cmd.deg_update = 1'b1;
            ST_OUT_LOAD:   o_cmd.out_load   = 1'b1;
            ST_OUT_WAIT: begin
                o_cmd.out_next = i_status.out_taken && !i_status.out_last;
            end
            default:       ;
        endcase
    end

endmodule

// File: rtl/ggc_datapath.sv
// Datapath: adjacency memory, degree and colour registers, output register.
module ggc_datapath #(
    parameter int MAX_VERTICES = ggc_pkg::DEF_MAX_VERTICES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [ggc_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                        i_in_accept,
    input  logic [ggc_pkg::IDX_W-1:0]   i_row_index,
    input  logic [ggc_pkg::ROW_W-1:0]   i_row_bits,
    input  logic                        i_row_last,
    input  logic                        i_out_ready,
    input  ggc_pkg::t_cmd               i_cmd,
    output ggc_pkg::t_status            o_status,
    output logic                        o_out_valid,
    output logic [ggc_pkg::IDX_W-1:0]   o_out_vertex,
    output logic [ggc_pkg::COLOR_W-1:0] o_out_color,
    output logic [ggc_pkg::CNT_W-1:0]   o_out_used,
    output logic                        o_out_last
);
    import ggc_pkg::*;

    localparam int CAP = (MAX_VERTICES < ROW_SLOTS) ? MAX_VERTICES : ROW_SLOTS;

    // Balanced popcount of one 32-bit row
    function automatic logic [CNT_W-1:0] f_popcount(input logic [ROW_W-1:0] bits);
        logic [1:0] s1 [16];
        logic [2:0] s2 [8];
        logic [3:0] s3 [4];
        logic [4:0] s4 [2];
        for (int i = 0; i < 16; i++) s1[i] = {1'b0, bits[2*i]} + {1'b0, bits[2*i+1]};
        for (int i = 0; i < 8; i++)  s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        for (int i = 0; i < 4; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        for (int i = 0; i < 2; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        return {1'b0, s4[0]} + {1'b0, s4[1]};
    endfunction

    logic [ROW_W-1:0]        r_mem [ROW_SLOTS];
    logic [ROW_W-1:0]        r_rd_data;
    logic [CNT_W-1:0]        r_vertex_count;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_round;
    logic [IDX_W-1:0]        r_best;
    logic signed [DEG_W-1:0] r_best_deg;
    logic signed [DEG_W-1:0] r_deg [ROW_SLOTS];
    logic [COLOR_W-1:0]      r_color [ROW_SLOTS];
    logic [COLOR_W-1:0]      r_color_count;
    logic [COLOR_W-1:0]      r_cand;
    logic [ROW_W-1:0]        r_row;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_vertex;
    logic [COLOR_W-1:0]      r_out_color;
    logic [CNT_W-1:0]        r_out_used;
    logic                    r_out_last;

    logic [CNT_W-1:0]        w_n_clamped;
    logic [ROW_W-1:0]        w_cmask;
    logic [IDX_W-1:0]        w_rd_addr;
    logic signed [DEG_W-1:0] w_scan_deg;
    logic [ROW_W-1:0]        w_match;
    logic                    w_conflict;
    logic                    w_found;
    logic                    w_out_taken;

    // Active vertex count, clamped to 1..CAP
    always_comb begin
        if (r_vertex_count == '0) begin
            w_n_clamped = CNT_W'(1);
        end else if (int'(r_vertex_count) > CAP) begin
            w_n_clamped = CNT_W'(CAP);
        end else begin
            w_n_clamped = r_vertex_count;
        end
    end

    // Columns at or beyond the active count are ignored
    always_comb begin
        for (int j = 0; j < ROW_W; j++) w_cmask[j] = (CNT_W'(j) < r_n);
    end

    // Colour test: does any neighbour hold the candidate colour
    always_comb begin
        for (int j = 0; j < ROW_SLOTS; j++) begin
            w_match[j] = r_row[j] && (r_color[j] == r_cand);
        end
    end
    assign w_conflict  = |w_match;
    assign w_found     = !w_conflict || (r_cand == r_color_count);
    assign w_rd_addr   = i_cmd.rd_best ? r_best : r_idx[IDX_W-1:0];
    assign w_scan_deg  = r_deg[r_idx[IDX_W-1:0]];
    assign w_out_taken = r_out_valid && i_out_ready;

    // Adjacency memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_in_accept && (int'(i_row_index) < MAX_VERTICES)) begin
            r_mem[i_row_index] <= i_row_bits;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (i_cfg_valid) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // Run control: count, index, round and colour count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n           <= CNT_W'(1);
            r_idx         <= '0;
            r_round       <= '0;
            r_color_count <= COLOR_W'(1);
        end else begin
            if (i_cmd.start) begin
                r_n           <= w_n_clamped;
                r_idx         <= '0;
                r_round       <= '0;
                r_color_count <= COLOR_W'(1);
            end
            if (i_cmd.init_wr || i_cmd.scan_step || i_cmd.out_next) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx <= CNT_W'(1);
            end
            if (i_cmd.color_step && w_found && w_conflict) begin
                r_color_count <= r_color_count + COLOR_W'(1);
            end
            if (i_cmd.deg_update) begin
                r_round <= r_round + CNT_W'(1);
                r_idx   <= '0;
            end
        end
    end

    // Highest-degree search, row latch and colour candidate
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_best     <= '0;
            r_best_deg <= r_deg[0];
        end else if (i_cmd.scan_step && (w_scan_deg > r_best_deg)) begin
            r_best     <= r_idx[IDX_W-1:0];
            r_best_deg <= w_scan_deg;
        end
        if (i_cmd.row_latch) begin
            r_row  <= r_rd_data & w_cmask;
            r_cand <= COLOR_W'(1);
        end else if (i_cmd.color_step && !w_found) begin
            r_cand <= r_cand + COLOR_W'(1);
        end
    end

    // Degree registers: init from popcount, then done-mark and neighbour decrement
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_wr) begin
            r_deg[r_idx[IDX_W-1:0]] <=
                $signed({1'b0, f_popcount(r_rd_data & w_cmask)});
        end else if (i_cmd.deg_update) begin
            for (int k = 0; k < ROW_SLOTS; k++) begin
                r_deg[k] <= ((IDX_W'(k) == r_best) ? DEGREE_DONE : r_deg[k])
                            - $signed({{(DEG_W-1){1'b0}}, r_row[k]});
            end
        end
    end

    // Colour registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int k = 0; k < ROW_SLOTS; k++) r_color[k] <= '0;
        end else if (i_cmd.color_step && w_found) begin
            r_color[r_best] <= w_conflict ? (r_cand + COLOR_W'(1)) : r_cand;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_vertex <= r_idx[IDX_W-1:0];
            r_out_color  <= r_color[r_idx[IDX_W-1:0]];
            r_out_used   <= r_color_count;
            r_out_last   <= (r_idx == (r_n - CNT_W'(1)));
        end
    end

    // Status back to the controller
    always_comb begin
        o_status.in_accept   = i_in_accept;
        o_status.in_last     = i_row_last;
        o_status.init_last   = (r_idx == (r_n - CNT_W'(1)));
        o_status.scan_done   = (r_idx >= r_n);
        o_status.color_found = w_found;
        o_status.last_round  = (r_round == (r_n - CNT_W'(1)));
        o_status.out_taken   = w_out_taken;
        o_status.out_last    = r_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_vertex = r_out_vertex;
    assign o_out_color  = r_out_color;
    assign o_out_used   = r_out_used;
    assign o_out_last   = r_out_last;

`ifndef NO_ASSERTIONS
    // A presented result always reports an active vertex
    a_out_vertex_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out_vertex} < r_n))
        else $error("result vertex beyond active count");

    // At most one colour is opened per round, so the count never passes n
    a_color_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_color_count != '0) && (r_color_count <= r_n))
        else $error("colour count out of range");

    // The picked vertex is marked done after each round
    a_picked_marked_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deg_update |=> (r_deg[$past(r_best)] < 0))
        else $error("picked vertex not marked done");
`endif

endmodule

// File: rtl/greedy_graph_coloring_top.sv
// Run sequence: degree set-up over the active vertices, then per round a degree scan, a row
// read and a colour search, then one result per vertex while the output side is ready.
// Throughput: one run at a time; rows load at one per cycle while idle, and the single-port
// degree scan and the colour test over the neighbour mask set the run time.
// Reset: synchronous, active low; vertex count returns to 32, colour count to 1, no results
// pending. Adjacency rows hold no reset value and need no clearing pass.
module greedy_graph_coloring_top #(
    parameter int MAX_VERTICES = ggc_pkg::DEF_MAX_VERTICES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel: vertex_count
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ggc_pkg::CNT_W-1:0]        i_cfg_data,
    // input rows
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ggc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // row_index[4:0], row_bits[36:5], pad
    input  logic                             s_axis_tlast,  // last_row
    // results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ggc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // vertex[4:0], color[10:5],
                                                            // colors_used[16:11], pad
    output logic                             m_axis_tlast   // last_result
);
    import ggc_pkg::*;

    t_cmd               w_cmd;
    t_status            w_status;
    logic               w_in_accept;
    logic [IDX_W-1:0]   w_out_vertex;
    logic [COLOR_W-1:0] w_out_color;
    logic [CNT_W-1:0]   w_out_used;

    // Input transaction
    assign s_axis_tready = w_cmd.in_ready;
    assign w_in_accept   = s_axis_tvalid && w_cmd.in_ready;
    assign o_cfg_ready   = 1'b1;

    ggc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    ggc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_accept  (w_in_accept),
        .i_row_index  (s_axis_tdata[IDX_W-1:0]),
        .i_row_bits   (s_axis_tdata[IDX_W+ROW_W-1:IDX_W]),
        .i_row_last   (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (m_axis_tvalid),
        .o_out_vertex (w_out_vertex),
        .o_out_color  (w_out_color),
        .o_out_used   (w_out_used),
        .o_out_last   (m_axis_tlast)
    );

    // Result packing, padded to whole bytes
    assign m_axis_tdata = {{(OUT_TDATA_W-IDX_W-COLOR_W-CNT_W){1'b0}},
                           w_out_used, w_out_color, w_out_vertex};

endmodule
